// File: sv/vef_pkg.sv
// Shared types and constants of the vertical emboss filter.
// No dependencies; compile first.
package vef_pkg;

	localparam int PIX_W         = 8;
	localparam int CFG_W         = 10;
	localparam int ROW_W         = 9;
	localparam int MAX_HEIGHT    = 512;
	localparam int MAX_WIDTH_DEF = 512;
	localparam int Q_DEPTH       = 2;
	localparam int APB_DW        = 32;
	localparam int PADDR_W       = 3;
	localparam int EMBOSS_BIAS   = 128;
	localparam int PIX_MAX       = 255;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(512);

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	// One queued input's worth of work for the output side
	typedef struct packed {
		pixel_t res;
		pixel_t px;
		logic   has_res;
		logic   has_px;
	} vef_entry_t;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
	} vef_cfg_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} vef_reg_t;

	typedef enum logic {
		BK_FIRST,
		BK_SECOND
	} back_state_t;

endpackage

// File: sv/vef_if.sv
// Pixel stream interfaces (valid/ready) for the emboss filter.
// Depends on vef_pkg.
interface vef_in_if;
	import vef_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface vef_out_if;
	import vef_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic             last_of_run;

	modport source (output valid, red_out, green_out, blue_out, last_of_run, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, last_of_run, output ready);
endinterface

// File: sv/vertical_emboss_filter_unit.sv
// Top level of the vertical emboss filter: configuration registers and the
// front end, work queue and back end. Depends on vef_pkg, vef_if, vef_front,
// vef_queue, vef_back.
//
// Usage:
//   pix_in  : RGB pixels in raster order, valid/ready, one transfer per ready clock.
//   pix_out : filtered pixels, valid/ready; last_of_run marks the final result
//             caused by one input pixel.
//   APB     : register 0 (0x0) image_width, register 1 (0x4) image_height,
//             10 bits each, reset to 512. Write only while the stream is idle.
// Output runs one row behind the input. Rows 1 and up each give the result
// for the row above; the last row also gives its own pixel, so there one
// input causes two output transfers. A one-row frame just passes through.
// An input passes the stage 1 registers, the queue and the output register;
// a second result follows the first. Throughput: 1 pixel per cycle while
// pix_out is ready; on the last row each pixel takes two transfers through
// the single output register. Line stores: one read at the incoming column,
// one write at the stage 1 column, per cycle; a forward path when they match.
// Reset clears counters, queue and output stage; line stores are not cleared
// and need no clearing pass. A stalled receiver fills the output register,
// then the 2-entry queue, then drops ready on pix_in.
module vertical_emboss_filter_unit #(
	parameter int MAX_WIDTH = vef_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vef_pkg::PADDR_W-1:0] paddr,
	input  logic [vef_pkg::APB_DW-1:0]  pwdata,
	output logic [vef_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	vef_in_if.sink                      pix_in,
	vef_out_if.source                   pix_out
);
	import vef_pkg::*;

	vef_cfg_t   cfg_q;
	vef_reg_t   reg_sel;
	logic       cfg_wr;
	logic       push_valid;
	logic       push_ready;
	vef_entry_t push_entry;
	logic       pop_valid;
	logic       pop_ready;
	vef_entry_t pop_entry;

	assign pready  = 1'b1;
	assign reg_sel = vef_reg_t'(paddr[PADDR_W-1]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	// Register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= CFG_RESET;
			cfg_q.height <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WIDTH:  cfg_q.width  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[CFG_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Register read
	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = APB_DW'(cfg_q.width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.height);
			default:    prdata = '0;
		endcase
	end

	vef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	vef_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	vef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.pix_out   (pix_out)
	);
endmodule

// File: sv/vef_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vef_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: sv/vef_front.sv
// Front end: accepts pixels, keeps row/column counters and both line stores,
// computes the delayed result and pushes work entries. Depends on vef_pkg, vef_ram.
module vef_front #(
	parameter int MAX_WIDTH = vef_pkg::MAX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	vef_in_if.sink              pix_in,
	input  vef_pkg::vef_cfg_t   cfg,
	output logic                push_valid,
	input  logic                push_ready,
	output vef_pkg::vef_entry_t push_entry
);
	import vef_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CMPW-1:0]  w_raw;
	logic [CMPW-1:0]  w_eff;
	logic [CFG_W-1:0] h_eff;
	logic             row_end;
	logic             last_row;
	logic             accept;
	logic             need_push;
	logic             s1_adv;
	pixel_t           px_in;

	logic             s1_valid_q;
	pixel_t           px_s1;
	logic [CW-1:0]    col_s1;
	logic             has_res_s1;
	logic             row1_s1;
	logic             last_s1;
	logic             byp_s1;
	pixel_t           fwd_prev_q;
	pixel_t           fwd_older_q;

	logic [3*PIX_W-1:0] prev_rd;
	logic [3*PIX_W-1:0] older_rd;
	pixel_t             prev_eff;
	pixel_t             above_eff;
	pixel_t             res_s1;

	function automatic logic [PIX_W-1:0] emboss(input logic [PIX_W-1:0] below,
			input logic [PIX_W-1:0] above);
		logic [PIX_W:0] v;
		v = (below > above) ? {1'b0, below - above} : '0;
		v = v + (PIX_W+1)'(EMBOSS_BIAS);
		return (v > (PIX_W+1)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : v[PIX_W-1:0];
	endfunction

	assign px_in = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

	// Clamp the frame size and classify the incoming pixel
	always_comb begin
		w_raw = CMPW'(cfg.width);
		if (cfg.width == '0) begin
			w_raw = CMPW'(1);
		end
		w_eff = (w_raw > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_raw;
		row_end = (CMPW'(col_q) + CMPW'(1)) >= w_eff;

		h_eff = cfg.height;
		if (cfg.height == '0) begin
			h_eff = CFG_W'(1);
		end else if (cfg.height > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end
		last_row = CFG_W'(row_q) >= (h_eff - CFG_W'(1));
	end

	// Stage 1 moves on when the queue takes its entry, or it has none
	assign need_push    = has_res_s1 | last_s1;
	assign s1_adv       = s1_valid_q & (push_ready | ~need_push);
	assign pix_in.ready = ~s1_valid_q | s1_adv;
	assign accept       = pix_in.valid & pix_in.ready;

	// Advance column and row counters per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Capture the pixel; forward the store write when the same column is read back
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= px_in;
			col_s1      <= col_q;
			has_res_s1  <= row_q != '0;
			row1_s1     <= row_q == ROW_W'(1);
			last_s1     <= last_row;
			byp_s1      <= s1_adv && (col_s1 == col_q);
			fwd_prev_q  <= px_s1;
			fwd_older_q <= prev_eff;
		end
	end

	vef_ram #(.WIDTH(3*PIX_W), .DEPTH(MAX_WIDTH)) u_prev_row (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (prev_rd)
	);

	vef_ram #(.WIDTH(3*PIX_W), .DEPTH(MAX_WIDTH)) u_older_row (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (prev_eff),
		.re    (accept),
		.raddr (col_q),
		.rdata (older_rd)
	);

	// Emboss against the pixel two rows up, or pass the top row through
	always_comb begin
		prev_eff  = byp_s1 ? fwd_prev_q  : pixel_t'(prev_rd);
		above_eff = byp_s1 ? fwd_older_q : pixel_t'(older_rd);
		if (row1_s1) begin
			res_s1 = prev_eff;
		end else begin
			res_s1.red   = emboss(px_s1.red,   above_eff.red);
			res_s1.green = emboss(px_s1.green, above_eff.green);
			res_s1.blue  = emboss(px_s1.blue,  above_eff.blue);
		end
	end

	assign push_valid         = s1_valid_q & need_push;
	assign push_entry.res     = res_s1;
	assign push_entry.px      = px_s1;
	assign push_entry.has_res = has_res_s1;
	assign push_entry.has_px  = last_s1;
endmodule

// File: sv/vef_queue.sv
// Short FIFO of work entries between the front and back ends.
// Depends on vef_pkg.
module vef_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  vef_pkg::vef_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output vef_pkg::vef_entry_t pop_entry
);
	import vef_pkg::*;

	localparam int PW   = $clog2(Q_DEPTH);
	localparam int CNTW = $clog2(Q_DEPTH + 1);

	vef_entry_t      slot_q [Q_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CNTW-1:0] count_q;
	logic            push;
	logic            pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(Q_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign push_ready = count_q != CNTW'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end
endmodule

// File: sv/vef_back.sv
// Back end: expands each work entry into one or two output transfers
// through a registered output stage. Depends on vef_pkg, vef_out_if.
module vef_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  vef_pkg::vef_entry_t pop_entry,
	vef_out_if.source           pix_out
);
	import vef_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic        load;
	logic        out_fire;
	logic        sel_res;
	logic        out_valid_q;
	pixel_t      out_px_q;
	logic        out_last_q;

	assign load     = ~out_valid_q | pix_out.ready;
	assign out_fire = load & pop_valid;

	// Send the delayed result first, then the entry's own pixel
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		sel_res   = 1'b0;
		case (state_q)
			BK_FIRST: begin
				if (pop_entry.has_res) begin
					sel_res = 1'b1;
					if (pop_entry.has_px) begin
						if (out_fire) begin
							state_d = BK_SECOND;
						end
					end else begin
						pop_ready = load;
					end
				end else begin
					pop_ready = load;
				end
			end
			BK_SECOND: begin
				pop_ready = load;
				if (out_fire) begin
					state_d = BK_FIRST;
				end
			end
			default: begin
				state_d = BK_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	// Load the output register when it is free or being drained
	always_ff @(posedge clk) begin
		if (out_fire) begin
			out_px_q   <= sel_res ? pop_entry.res : pop_entry.px;
			out_last_q <= sel_res ? ~pop_entry.has_px : 1'b1;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.red_out     = out_px_q.red;
	assign pix_out.green_out   = out_px_q.green;
	assign pix_out.blue_out    = out_px_q.blue;
	assign pix_out.last_of_run = out_last_q;
endmodule

// File: verif/vertical_emboss_filter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of vertical_emboss_filter_unit: whole RGB frames over many image sizes and
// idling patterns, each output transfer checked against an in-bench line-store predictor.
// Depends on vef_pkg, vef_if and the filter RTL.
module vertical_emboss_filter_unit_tb;
	import vef_pkg::*;

	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 360;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		pixel_t pix;
		logic   last;
	} out_pixel_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	vef_in_if  pix_in_bus ();
	vef_out_if pix_out_bus ();

	vertical_emboss_filter_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	pixel_t           pending_pixels[$];
	out_pixel_t       expected_pixels[$];
	pixel_t           previous_row [MAX_W];
	pixel_t           older_row [MAX_W];
	int               column_count;
	int               row_count;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	int               queued_count;
	int               accepted_count;
	int               error_count;
	int               cycle_count;
	int               send_idle_pct;
	int               recv_stall_pct;
	bit               in_taken;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Register value to the size in use: zero counts as one, large values saturate
	function automatic int clamp_dim(logic [CFG_W-1:0] v, int top);
		if (v == 0)
			return 1;
		return (int'(v) > top) ? top : int'(v);
	endfunction

	function automatic logic [PIX_W-1:0] emboss_channel(logic [PIX_W-1:0] below,
			logic [PIX_W-1:0] above);
		logic [PIX_W:0] v;
		v = (below > above) ? {1'b0, below - above} : '0;
		v = v + (PIX_W+1)'(EMBOSS_BIAS);
		return (v > (PIX_W+1)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : v[PIX_W-1:0];
	endfunction

	// Advance the line stores and counters by one pixel; queue the results it causes
	task automatic predict_emboss(input pixel_t px);
		int     w;
		int     h;
		int     col;
		bit     last_row;
		pixel_t prev;
		pixel_t above;
		pixel_t res;
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		col = (column_count >= MAX_W) ? MAX_W - 1 : column_count;
		last_row = (row_count >= h - 1);
		prev = previous_row[col];
		above = older_row[col];
		if (row_count >= 1) begin
			// top row passes through; deeper rows take below minus above, floored at zero, plus the bias
			if (row_count == 1) begin
				res = prev;
			end else begin
				res.red   = emboss_channel(px.red, above.red);
				res.green = emboss_channel(px.green, above.green);
				res.blue  = emboss_channel(px.blue, above.blue);
			end
			expected_pixels.push_back('{pix: res, last: !last_row});
		end
		// bottom row also emits itself
		if (last_row)
			expected_pixels.push_back('{pix: px, last: 1'b1});
		older_row[col] = prev;
		previous_row[col] = px;
		if (column_count + 1 >= w) begin
			column_count = 0;
			row_count = last_row ? 0 : row_count + 1;
		end else begin
			column_count = column_count + 1;
		end
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Sample both channels: predict on input transfers, check output transfers
	always @(posedge clk) begin
		out_pixel_t want;
		in_taken = 1'b0;
		if (arst_n) begin
			if (pix_in_bus.valid && pix_in_bus.ready) begin
				in_taken = 1'b1;
				accepted_count++;
				predict_emboss({pix_in_bus.red_in, pix_in_bus.green_in, pix_in_bus.blue_in});
			end
			if (pix_out_bus.valid && pix_out_bus.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result with nothing expected: red_out %0d green_out %0d blue_out %0d last_of_run %0d",
						pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out,
						pix_out_bus.last_of_run);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("red_out", want.pix.red, pix_out_bus.red_out);
					check_field("green_out", want.pix.green, pix_out_bus.green_out);
					check_field("blue_out", want.pix.blue, pix_out_bus.blue_out);
					check_field("last_of_run", want.last, pix_out_bus.last_of_run);
				end
			end
		end
	end

	// Drive the input channel from the pending queue; hold valid until the transfer
	always @(negedge clk) begin
		pixel_t nxt;
		if (!pix_in_bus.valid || in_taken) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_pixels.pop_front();
				pix_in_bus.red_in   <= nxt.red;
				pix_in_bus.green_in <= nxt.green;
				pix_in_bus.blue_in  <= nxt.blue;
				pix_in_bus.valid    <= 1'b1;
			end else begin
				pix_in_bus.valid <= 1'b0;
			end
		end
		pix_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vertical_emboss_filter_unit_tb: done, errors");
			$finish;
		end
	end

	// Write a register over APB, then read it back
	task automatic config_reg(input vef_reg_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= ($urandom() & ~APB_DW'(2**CFG_W - 1)) | APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		psel    <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", APB_DW'(value), prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 51;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 51;
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct = 32;
			end
		endcase
	endtask

	task automatic push_pixel(input pixel_t px);
		pending_pixels.push_back(px);
		queued_count++;
	endtask

	// Channel values lean toward the extremes to reach both clamps
	function automatic logic [PIX_W-1:0] random_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return PIX_W'(PIX_MAX);
			default: return PIX_W'($urandom_range(PIX_MAX));
		endcase
	endfunction

	// Queue whole frames of random pixels at the current size
	task automatic queue_frames(input int frames, output int count);
		pixel_t px;
		count = frames * clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_HEIGHT);
		for (int i = 0; i < count; i++) begin
			px.red   = random_channel();
			px.green = random_channel();
			px.blue  = random_channel();
			push_pixel(px);
		end
	endtask

	// Wait for every transfer to land, then let the pipeline settle
	task automatic wait_idle();
		do @(negedge clk); while (accepted_count != queued_count || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		pixel_t directed_frame [12] = '{
			24'h000000, 24'hFFFFFF, 24'h00FF00,
			24'h804020, 24'h010203, 24'hFF0080,
			24'hFFFFFF, 24'h000000, 24'hFF00FF,
			24'h000000, 24'hFFFFFF, 24'hFF0180
		};
		logic [CFG_W-1:0] w_val;
		logic [CFG_W-1:0] h_val;
		int               count;
		int               random_sent;
		int               phase;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_in_bus.valid = 1'b0;
		pix_in_bus.red_in = '0;
		pix_in_bus.green_in = '0;
		pix_in_bus.blue_in = '0;
		pix_out_bus.ready = 1'b0;
		width_reg = CFG_RESET;
		height_reg = CFG_RESET;
		column_count = 0;
		row_count = 0;
		queued_count = 0;
		accepted_count = 0;
		error_count = 0;
		cycle_count = 0;
		set_idling(IDLE_NONE);
		foreach (previous_row[i]) begin
			previous_row[i] = '0;
			older_row[i] = '0;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x4 frame: pass-through rows, both clamps, mixed channels, double output
		config_reg(REG_WIDTH, CFG_W'(3));
		config_reg(REG_HEIGHT, CFG_W'(4));
		foreach (directed_frame[i])
			push_pixel(directed_frame[i]);
		wait_idle();

		// zero size is taken as a single pixel frame
		config_reg(REG_WIDTH, '0);
		config_reg(REG_HEIGHT, '0);
		push_pixel(24'hFF00FF);
		push_pixel(24'h00FF00);
		wait_idle();

		// widest row and tallest frame, both through saturating values
		set_idling(IDLE_BOTH);
		config_reg(REG_WIDTH, '1);
		config_reg(REG_HEIGHT, CFG_W'(1));
		queue_frames(1, count);
		wait_idle();
		set_idling(IDLE_RECEIVER);
		config_reg(REG_WIDTH, CFG_W'(1));
		config_reg(REG_HEIGHT, '1);
		queue_frames(1, count);
		wait_idle();

		// small random frames, cycling through the idling patterns
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			w_val = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(2)) :
				CFG_W'($urandom_range(3, 20));
			h_val = ($urandom_range(4) == 0) ? CFG_W'($urandom_range(2)) :
				CFG_W'($urandom_range(3, 9));
			set_idling(idle_mode_t'(phase % 4));
			config_reg(REG_WIDTH, w_val);
			config_reg(REG_HEIGHT, h_val);
			queue_frames($urandom_range(1, 3), count);
			random_sent += count;
			phase++;
			wait_idle();
		end

		if (error_count == 0)
			$display("vertical_emboss_filter_unit_tb: done, clean");
		else
			$display("vertical_emboss_filter_unit_tb: done, errors");
		$finish;
	end

endmodule
